### src/twhb_pkg.sv
// Package for the three-wire handshake bus engine: beat types, codes, sizes.
// No dependencies.
`default_nettype none
package twhb_pkg;
   localparam int QueueDepth = 512;
   localparam int QAW = $clog2(QueueDepth);
   localparam int QCW = QAW + 1;

   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_PUSH  = 2'd1;
   localparam logic [1:0] ACT_CLOSE = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_BUSY    = 2'd1;
   localparam logic [1:0] ST_TIMEOUT = 2'd2;

   localparam logic [2:0] REG_HALF    = 3'd0;
   localparam logic [2:0] REG_TIMEOUT = 3'd1;
   localparam logic [2:0] REG_POLL    = 3'd2;
   localparam logic [2:0] REG_LIMIT   = 3'd3;
   localparam logic [2:0] REG_GAP     = 3'd4;
   localparam logic [2:0] REG_RXEN    = 3'd5;

   typedef enum logic [3:0] {
      M_IDLE, M_ARB1, M_ARB2, M_TX_DATA, M_TX_LOW, M_TX_HIGH, M_TX_CLK,
      M_TX_GAP, M_RX_LOW, M_RX_HOLD, M_RX_HIGH
   } mode_type;

   typedef struct packed {
      logic [1:0] action;
      logic       busy_level;
      logic       clock_level;
      logic       data_level;
      logic [7:0] send_byte;
   } req_type;

   typedef struct packed {
      logic       busy_drive_low;
      logic       clock_drive_low;
      logic       data_drive_low;
      logic       received_valid;
      logic [7:0] received_byte;
      logic       frame_done;
      logic [1:0] frame_status;
      logic [9:0] frame_sent_count;
      logic       queue_dropped;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  half_bit_ticks;
      logic [15:0] handshake_timeout_ticks;
      logic [7:0]  idle_poll_ticks;
      logic [7:0]  idle_poll_limit;
      logic [7:0]  byte_gap_ticks;
      logic        receive_enable;
   } cfg_type;

   // queue status handed from front to back each beat
   typedef struct packed {
      logic [QCW-1:0] fill;
      logic [7:0]     head_byte;
   } qstat_type;

   function automatic logic [15:0] load_wait(input logic [15:0] n);
      return (n != 16'd0) ? n - 16'd1 : 16'd0;
   endfunction
endpackage
`default_nettype wire

### src/twhb_queue.sv
// Front part: transmit byte queue with registered head read.
// Depends on twhb_pkg.
`default_nettype none
module twhb_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire logic [7:0]            push_byte,
   input  wire logic [twhb_pkg::QCW-1:0] pop_count,
   output logic                       dropped,
   output twhb_pkg::qstat_type        stat
);
   logic [7:0] mem [twhb_pkg::QueueDepth];
   logic [twhb_pkg::QAW-1:0] head_ff, head_in, tail_ff;
   logic [twhb_pkg::QCW-1:0] fill_ff, fill_in;
   logic [7:0] rd_ff;
   logic       do_push;
   logic [twhb_pkg::QAW:0] hsum;

   assign do_push = push && (fill_ff < twhb_pkg::QCW'(twhb_pkg::QueueDepth));
   assign dropped = push && !do_push;
   assign hsum = {1'b0, head_ff} + pop_count;
   always_comb begin
      if (hsum >= (twhb_pkg::QAW+1)'(twhb_pkg::QueueDepth))
         head_in = twhb_pkg::QAW'(hsum - (twhb_pkg::QAW+1)'(twhb_pkg::QueueDepth));
      else
         head_in = hsum[twhb_pkg::QAW-1:0];
      fill_in = fill_ff - pop_count + twhb_pkg::QCW'(do_push);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         fill_ff <= fill_in;
         if (do_push)
            tail_ff <= (tail_ff == twhb_pkg::QAW'(twhb_pkg::QueueDepth - 1)) ? '0
                       : tail_ff + 1'b1;
      end
   end

   // read-ahead: next head byte is registered from head_in; bypass a push to empty slot
   always_ff @(posedge clock) begin
      if (do_push) mem[tail_ff] <= push_byte;
      if (do_push && tail_ff == head_in) rd_ff <= push_byte;
      else rd_ff <= mem[head_in];
   end

   assign stat.fill = fill_ff;
   assign stat.head_byte = rd_ff;
endmodule
`default_nettype wire

### src/twhb_engine.sv
// Back part: tick-driven line engine for arbitration, transmit and receive.
// Depends on twhb_pkg.
`default_nettype none
module twhb_engine (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 tick,
   input  wire logic                 close,
   input  wire logic                 busy,
   input  wire logic                 clk,
   input  wire logic                 dat,
   input  wire twhb_pkg::cfg_type    cfg,
   input  wire twhb_pkg::qstat_type  qs,
   output logic [twhb_pkg::QCW-1:0]  pop_count,
   output logic [2:0]                drv,
   output logic                      rx_valid,
   output logic [7:0]                rx_byte,
   output logic                      done,
   output logic [1:0]                status,
   output logic [9:0]                count
);
   twhb_pkg::mode_type mode_ff, mode_in;
   logic [3:0]  bit_ff, bit_in;
   logic [7:0]  sh_ff, sh_in, poll_ff, poll_in;
   logic [15:0] wt_ff, wt_in;
   logic [twhb_pkg::QCW-1:0] rem_ff, rem_in;
   logic [9:0]  sent_ff, sent_in;
   logic        pend_ff, pend_in, pb_ff, pb_in;
   logic [2:0]  drv_ff, drv_in;   // {data, clk, busy}
   logic [twhb_pkg::QCW-1:0] fill_now;
   logic [twhb_pkg::QCW-1:0] pop_v;
   logic        fin;
   logic [1:0]  fst;
   logic        tmo;

   assign tmo = wt_ff >= cfg.handshake_timeout_ticks;

   always_comb begin
      mode_in = mode_ff; bit_in = bit_ff; sh_in = sh_ff; poll_in = poll_ff;
      wt_in = wt_ff; rem_in = rem_ff; sent_in = sent_ff; pend_in = pend_ff;
      pb_in = pb_ff; drv_in = drv_ff;
      pop_v = '0; fin = 1'b0; fst = twhb_pkg::ST_OK;
      rx_valid = 1'b0; rx_byte = 8'd0;
      fill_now = qs.fill;
      if (close) pend_in = 1'b1;
      if (tick) begin
         pb_in = busy;
         case (mode_ff)
            twhb_pkg::M_IDLE: begin
               if (cfg.receive_enable && pb_ff && !busy) begin
                  sh_in = '0; bit_in = '0; wt_in = '0; drv_in = 3'b001;
                  mode_in = twhb_pkg::M_RX_LOW;
               end else if (pend_ff) begin
                  pend_in = 1'b0;
                  if (fill_now != '0) begin
                     rem_in = fill_now; sent_in = '0; poll_in = '0;
                     if (busy && clk) begin
                        mode_in = twhb_pkg::M_ARB2;
                        wt_in = twhb_pkg::load_wait({8'd0, cfg.idle_poll_ticks});
                     end else if (cfg.idle_poll_limit == 8'd0) begin
                        fin = 1'b1; fst = twhb_pkg::ST_BUSY;
                     end else begin
                        mode_in = twhb_pkg::M_ARB1; poll_in = 8'd1;
                        wt_in = twhb_pkg::load_wait({8'd0, cfg.idle_poll_ticks});
                     end
                  end
               end
            end
            twhb_pkg::M_ARB1, twhb_pkg::M_ARB2: begin
               if (wt_ff != '0) wt_in = wt_ff - 1'b1;
               else if (busy && clk) begin
                  if (mode_ff == twhb_pkg::M_ARB1) begin
                     mode_in = twhb_pkg::M_ARB2; poll_in = '0;
                     wt_in = twhb_pkg::load_wait({8'd0, cfg.idle_poll_ticks});
                  end else if (rem_ff == '0 || fill_now == '0) begin
                     drv_in = drv_ff | 3'b001; fin = 1'b1;
                  end else begin
                     sh_in = qs.head_byte; bit_in = '0; wt_in = '0; drv_in = 3'b001;
                     mode_in = twhb_pkg::M_TX_DATA;
                  end
               end else if (poll_ff >= cfg.idle_poll_limit) begin
                  fin = 1'b1; fst = twhb_pkg::ST_BUSY;
               end else begin
                  poll_in = poll_ff + 1'b1;
                  wt_in = twhb_pkg::load_wait({8'd0, cfg.idle_poll_ticks});
               end
            end
            twhb_pkg::M_TX_DATA: begin
               if (dat) begin
                  drv_in = {~sh_ff[7], 2'b11};
                  wt_in = twhb_pkg::load_wait({8'd0, cfg.half_bit_ticks});
                  mode_in = twhb_pkg::M_TX_LOW;
               end else if (tmo) begin
                  fin = 1'b1; fst = twhb_pkg::ST_TIMEOUT;
               end else wt_in = wt_ff + 1'b1;
            end
            twhb_pkg::M_TX_LOW: begin
               if (wt_ff != '0) wt_in = wt_ff - 1'b1;
               else begin
                  drv_in = drv_ff & 3'b101;
                  if (bit_ff >= 4'd7) begin
                     wt_in = '0; mode_in = twhb_pkg::M_TX_CLK;
                  end else begin
                     wt_in = twhb_pkg::load_wait({8'd0, cfg.half_bit_ticks});
                     mode_in = twhb_pkg::M_TX_HIGH;
                  end
               end
            end
            twhb_pkg::M_TX_HIGH, twhb_pkg::M_TX_CLK: begin
               if (mode_ff == twhb_pkg::M_TX_HIGH && wt_ff != '0) wt_in = wt_ff - 1'b1;
               else begin
                  // high phase expired: a low clk enters M_TX_CLK with the wait timer at one
                  if (clk) begin
                     if (bit_ff >= 4'd7) begin
                        drv_in = 3'b010;
                        if (fill_now != '0) pop_v = twhb_pkg::QCW'(1);
                        if (rem_ff != '0) rem_in = rem_ff - 1'b1;
                        sent_in = sent_ff + 1'b1;
                        wt_in = twhb_pkg::load_wait({8'd0, cfg.byte_gap_ticks});
                        mode_in = twhb_pkg::M_TX_GAP;
                     end else begin
                        bit_in = bit_ff + 1'b1;
                        sh_in = {sh_ff[6:0], 1'b0};
                        drv_in = {~sh_ff[6], 2'b11};
                        wt_in = twhb_pkg::load_wait({8'd0, cfg.half_bit_ticks});
                        mode_in = twhb_pkg::M_TX_LOW;
                     end
                  end else begin
                     mode_in = twhb_pkg::M_TX_CLK;
                     if (mode_ff == twhb_pkg::M_TX_HIGH) wt_in = 16'd1;
                     else if (tmo) begin
                        fin = 1'b1; fst = twhb_pkg::ST_TIMEOUT;
                     end else wt_in = wt_ff + 1'b1;
                     // fresh from high phase: timer 0 compared against timeout
                     if (mode_ff == twhb_pkg::M_TX_HIGH &&
                         cfg.handshake_timeout_ticks == 16'd0) begin
                        fin = 1'b1; fst = twhb_pkg::ST_TIMEOUT;
                     end
                  end
               end
            end
            twhb_pkg::M_TX_GAP: begin
               if (wt_ff != '0) wt_in = wt_ff - 1'b1;
               else if (rem_ff != '0 && fill_now != '0) begin
                  sh_in = qs.head_byte; bit_in = '0; wt_in = '0; drv_in = 3'b001;
                  mode_in = twhb_pkg::M_TX_DATA;
               end else fin = 1'b1;
            end
            twhb_pkg::M_RX_LOW: begin
               if (!clk) begin
                  drv_in = 3'b011;
                  wt_in = twhb_pkg::load_wait({8'd0, cfg.half_bit_ticks});
                  mode_in = twhb_pkg::M_RX_HOLD;
               end else if (tmo) begin
                  drv_in = 3'b100; mode_in = twhb_pkg::M_IDLE;
               end else wt_in = wt_ff + 1'b1;
            end
            twhb_pkg::M_RX_HOLD: begin
               if (wt_ff != '0) wt_in = wt_ff - 1'b1;
               else begin
                  sh_in = {sh_ff[6:0], dat}; drv_in = 3'b001; wt_in = '0;
                  mode_in = twhb_pkg::M_RX_HIGH;
               end
            end
            twhb_pkg::M_RX_HIGH: begin
               if (clk) begin
                  if (bit_ff >= 4'd7) begin
                     rx_valid = 1'b1; rx_byte = sh_ff;
                     drv_in = 3'b100; mode_in = twhb_pkg::M_IDLE;
                  end else begin
                     bit_in = bit_ff + 1'b1; wt_in = '0;
                     mode_in = twhb_pkg::M_RX_LOW;
                  end
               end else if (tmo) begin
                  drv_in = 3'b100; mode_in = twhb_pkg::M_IDLE;
               end else wt_in = wt_ff + 1'b1;
            end
            default: begin
               drv_in = 3'b100; mode_in = twhb_pkg::M_IDLE;
            end
         endcase
      end
      if (fin) begin
         if (fst != twhb_pkg::ST_BUSY) drv_in = 3'b100;
         // discard what is left of the frame (after any pop this beat)
         if ((fill_now - pop_v) < rem_in) pop_v = fill_now;
         else pop_v = pop_v + rem_in;
         rem_in = '0; mode_in = twhb_pkg::M_IDLE;
      end
      pop_count = pop_v;
      done = fin;
      status = fin ? fst : twhb_pkg::ST_OK;
      count = fin ? sent_in : 10'd0;
      drv = drv_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= twhb_pkg::M_IDLE; bit_ff <= '0; sh_ff <= '0; wt_ff <= '0;
         poll_ff <= '0; rem_ff <= '0; sent_ff <= '0; pend_ff <= 1'b0;
         pb_ff <= 1'b1; drv_ff <= 3'b100;
      end else begin
         mode_ff <= mode_in; bit_ff <= bit_in; sh_ff <= sh_in; wt_ff <= wt_in;
         poll_ff <= poll_in; rem_ff <= rem_in; sent_ff <= sent_in;
         pend_ff <= pend_in; pb_ff <= pb_in; drv_ff <= drv_in;
      end
   end
endmodule
`default_nettype wire

### src/three_wire_handshake_bus_engine.sv
// Top level of the three-wire handshake bus engine.
// Depends on twhb_pkg, twhb_queue and twhb_engine.
//
// Usage:
//   req channel: one beat per item; action tick carries sampled busy, clock
//   and data levels (one 5 us tick), push/close beats queue send_byte.
//   rsp channel: exactly one beat per req beat, in order, giving the line
//   drives, a received byte, and frame completion with status and count.
//   csr port: APB-style, six registers at 4*i, pready tied high; write only
//   while idle.
// Throughput: one beat per cycle while req_ready is high. The engine state update and the queue
//   head read (a registered memory port, read ahead) set this.
// Reset: synchronous; engine idle, queue empty, data driven low, registers
//   at their defaults. The queue memory itself is not cleared.
// Stall: a rsp register plus one skid entry hold results; req_ready drops
//   only when both are full, so the engine never loses a result.
`default_nettype none
module three_wire_handshake_bus_engine (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire twhb_pkg::req_type   req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output twhb_pkg::rsp_type        rsp_data,
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [4:0]          paddr,
   input  wire logic [31:0]         pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);
   twhb_pkg::cfg_type cfg_ff;
   twhb_pkg::qstat_type qs;
   twhb_pkg::rsp_type res, skid_ff;
   logic skid_vld_ff, acc, is_tick, is_push, is_close, dropped, wr;
   logic [twhb_pkg::QCW-1:0] pop;
   logic [2:0] drv, rsel;
   logic rxv, dn;
   logic [7:0] rxb;
   logic [1:0] st;
   logic [9:0] cnt;

   assign pready = 1'b1;
   assign rsel = paddr[4:2];
   assign wr = psel && penable && pwrite;

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{8'd5, 16'd2000, 8'd10, 8'd200, 8'd20, 1'b1};
      end else if (wr) begin
         case (rsel)
            twhb_pkg::REG_HALF:    cfg_ff.half_bit_ticks <= pwdata[7:0];
            twhb_pkg::REG_TIMEOUT: cfg_ff.handshake_timeout_ticks <= pwdata[15:0];
            twhb_pkg::REG_POLL:    cfg_ff.idle_poll_ticks <= pwdata[7:0];
            twhb_pkg::REG_LIMIT:   cfg_ff.idle_poll_limit <= pwdata[7:0];
            twhb_pkg::REG_GAP:     cfg_ff.byte_gap_ticks <= pwdata[7:0];
            twhb_pkg::REG_RXEN:    cfg_ff.receive_enable <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (rsel)
         twhb_pkg::REG_HALF:    prdata = {24'd0, cfg_ff.half_bit_ticks};
         twhb_pkg::REG_TIMEOUT: prdata = {16'd0, cfg_ff.handshake_timeout_ticks};
         twhb_pkg::REG_POLL:    prdata = {24'd0, cfg_ff.idle_poll_ticks};
         twhb_pkg::REG_LIMIT:   prdata = {24'd0, cfg_ff.idle_poll_limit};
         twhb_pkg::REG_GAP:     prdata = {24'd0, cfg_ff.byte_gap_ticks};
         twhb_pkg::REG_RXEN:    prdata = {31'd0, cfg_ff.receive_enable};
         default:               prdata = 32'd0;
      endcase
   end

   // accept while the skid entry is free
   assign req_ready = !skid_vld_ff;
   assign acc = req_valid && req_ready;
   assign is_tick  = acc && req_data.action == twhb_pkg::ACT_TICK;
   assign is_push  = acc && (req_data.action == twhb_pkg::ACT_PUSH ||
                             req_data.action == twhb_pkg::ACT_CLOSE);
   assign is_close = acc && req_data.action == twhb_pkg::ACT_CLOSE;

   twhb_queue u_queue (
      .clock(clock), .reset(reset), .push(is_push), .push_byte(req_data.send_byte),
      .pop_count(pop), .dropped(dropped), .stat(qs)
   );

   twhb_engine u_engine (
      .clock(clock), .reset(reset), .tick(is_tick), .close(is_close),
      .busy(req_data.busy_level), .clk(req_data.clock_level),
      .dat(req_data.data_level), .cfg(cfg_ff), .qs(qs), .pop_count(pop),
      .drv(drv), .rx_valid(rxv), .rx_byte(rxb), .done(dn), .status(st), .count(cnt)
   );

   assign res = '{drv[0], drv[1], drv[2], rxv, rxb, dn, st, cnt, dropped};

   // output register with one skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         if (!rsp_valid || rsp_ready) begin
            if (skid_vld_ff) begin
               rsp_valid <= 1'b1; rsp_data <= skid_ff; skid_vld_ff <= 1'b0;
            end else begin
               rsp_valid <= acc; rsp_data <= res;
            end
         end else if (acc) begin
            skid_vld_ff <= 1'b1; skid_ff <= res;
         end
      end
   end
endmodule
`default_nettype wire

### src/twhb_checker.sv
// Port-level checker for the three-wire handshake bus engine, with bind.
// Depends on twhb_pkg and three_wire_handshake_bus_engine.
`default_nettype none
module twhb_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire twhb_pkg::rsp_type rsp_data,
   input wire logic              pready
);
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp changed under stall");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.frame_done |-> rsp_data.frame_status == twhb_pkg::ST_OK
         && rsp_data.frame_sent_count == 10'd0)
      else $error("status without frame end");
   a_rx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.received_valid |-> !rsp_data.frame_done)
      else $error("receive and frame end together");
   a_acc: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted beat gave no result");
   a_pready: assert property (@(posedge clock) pready)
      else $error("pready low");
endmodule

bind three_wire_handshake_bus_engine twhb_checker u_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data), .pready(pready)
);
`default_nettype wire
